// ----- sv/pnm_pkg.sv -----
// Package for the palette nearest-match block: sizes, codes and shared types.
package pnm_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int COLOR_W       = 8;
  localparam int CODE_W        = 8;
  localparam int GLYPH_W       = 16;
  localparam int STATUS_W      = 3;
  localparam int OUT_IDX_W     = 12;
  localparam int SQ_W          = 2 * COLOR_W;
  localparam int DIST_W        = 18;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } pnm_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_MATCH     = 3'd3,
    ST_EMPTY     = 3'd4
  } pnm_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } pnm_state_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [CODE_W-1:0]  background;
    logic [CODE_W-1:0]  foreground;
    logic [GLYPH_W-1:0] glyph;
  } pnm_entry_t;

  localparam int ENTRY_W = $bits(pnm_entry_t);

  // sequencer -> distance unit
  typedef struct packed {
    logic             start;     // clear running best before a scan
    logic             rd_valid;  // table read data valid this cycle
    logic [IDX_W-1:0] rd_index;  // index of that read data
  } pnm_scan_t;

  // distance unit -> sequencer
  typedef struct packed {
    logic               busy;    // a distance is still in flight
    logic               dup;     // an entry of equal color was seen
    logic [IDX_W-1:0]   index;
    logic [DIST_W-1:0]  distance;
    logic [CODE_W-1:0]  background;
    logic [CODE_W-1:0]  foreground;
    logic [GLYPH_W-1:0] glyph;
  } pnm_best_t;

  function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W+OUT_IDX_W-1:0] wide;
    wide = {{OUT_IDX_W{1'b0}}, idx};
    return wide[OUT_IDX_W-1:0];
  endfunction

endpackage

// ----- sv/pnm_if.sv -----
// Valid/ready channel interfaces for the input items and the result items.
interface pnm_in_if;
  import pnm_pkg::*;

  logic               valid;
  logic               ready;
  logic [0:0]         opcode;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [CODE_W-1:0]  background;
  logic [CODE_W-1:0]  foreground;
  logic [GLYPH_W-1:0] glyph;

  modport source (
    output valid, opcode, red, green, blue, background, foreground, glyph,
    input  ready
  );
  modport sink (
    input  valid, opcode, red, green, blue, background, foreground, glyph,
    output ready
  );
endinterface

interface pnm_out_if;
  import pnm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [OUT_IDX_W-1:0] entry_index;
  logic [DIST_W-1:0]    distance;
  logic [CODE_W-1:0]    match_background;
  logic [CODE_W-1:0]    match_foreground;
  logic [GLYPH_W-1:0]   match_glyph;

  modport source (
    output valid, status, entry_index, distance, match_background, match_foreground,
           match_glyph,
    input  ready
  );
  modport sink (
    input  valid, status, entry_index, distance, match_background, match_foreground,
           match_glyph,
    output ready
  );
endinterface

// ----- sv/pnm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/pnm_dist.sv -----
// Shared distance unit: squared color distance, equality and running minimum.
module pnm_dist (
  input  logic               clk,
  input  logic               rst_n,
  input  pnm_pkg::pnm_scan_t scan,
  input  pnm_pkg::pnm_entry_t rd_data,
  input  pnm_pkg::pnm_entry_t key,
  output pnm_pkg::pnm_best_t best
);
  import pnm_pkg::*;

  logic [COLOR_W-1:0] dr, dg, db;
  logic [SQ_W-1:0]    sr, sg, sb;
  logic [DIST_W-1:0]  dsum;

  // stage B registers
  logic               v2_r, v2_nxt;
  logic [IDX_W-1:0]   idx2_r;
  logic [DIST_W-1:0]  d2_r;
  logic               eq2_r;
  logic [CODE_W-1:0]  bg2_r, fg2_r;
  logic [GLYPH_W-1:0] gl2_r;

  // running best
  logic               found_r, found_nxt;
  logic               dup_r, dup_nxt;
  logic               take;
  logic [IDX_W-1:0]   bidx_r;
  logic [DIST_W-1:0]  bdist_r;
  logic [CODE_W-1:0]  bbg_r, bfg_r;
  logic [GLYPH_W-1:0] bgl_r;

  always_comb begin
    dr   = (rd_data.red   > key.red)   ? rd_data.red   - key.red   : key.red   - rd_data.red;
    dg   = (rd_data.green > key.green) ? rd_data.green - key.green : key.green - rd_data.green;
    db   = (rd_data.blue  > key.blue)  ? rd_data.blue  - key.blue  : key.blue  - rd_data.blue;
    sr   = SQ_W'(dr) * SQ_W'(dr);
    sg   = SQ_W'(dg) * SQ_W'(dg);
    sb   = SQ_W'(db) * SQ_W'(db);
    dsum = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
  end

  assign v2_nxt = scan.rd_valid;
  // strict less keeps the lowest index on ties
  assign take   = v2_r && (!found_r || (d2_r < bdist_r));

  always_comb begin
    found_nxt = found_r;
    dup_nxt   = dup_r;
    if (scan.start) begin
      found_nxt = 1'b0;
      dup_nxt   = 1'b0;
    end else if (v2_r) begin
      found_nxt = 1'b1;
      dup_nxt   = dup_r | eq2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      found_r <= 1'b0;
      dup_r   <= 1'b0;
    end else begin
      v2_r    <= v2_nxt;
      found_r <= found_nxt;
      dup_r   <= dup_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.rd_valid) begin
      idx2_r <= scan.rd_index;
      d2_r   <= dsum;
      eq2_r  <= (dr == '0) && (dg == '0) && (db == '0);
      bg2_r  <= rd_data.background;
      fg2_r  <= rd_data.foreground;
      gl2_r  <= rd_data.glyph;
    end
    if (take) begin
      bidx_r  <= idx2_r;
      bdist_r <= d2_r;
      bbg_r   <= bg2_r;
      bfg_r   <= fg2_r;
      bgl_r   <= gl2_r;
    end
  end

  always_comb begin
    best.busy       = v2_r;
    best.dup        = dup_r;
    best.index      = bidx_r;
    best.distance   = bdist_r;
    best.background = bbg_r;
    best.foreground = bfg_r;
    best.glyph      = bgl_r;
  end

endmodule

// ----- sv/pnm_seq.sv -----
// Sequencer: item capture, table scan, entry append and result register.
module pnm_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  pnm_in_if.sink               in_ch,
  pnm_out_if.source            out_ch,
  output pnm_pkg::pnm_scan_t   scan,
  input  pnm_pkg::pnm_best_t   best,
  output pnm_pkg::pnm_entry_t  key,
  output logic                 ram_re,
  output logic [pnm_pkg::IDX_W-1:0] ram_raddr,
  output logic                 ram_we,
  output logic [pnm_pkg::IDX_W-1:0] ram_waddr
);
  import pnm_pkg::*;

  pnm_state_t state_r, state_nxt;

  logic             in_fire, fin_go, last_issue, full, do_append;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             rdv_r;
  logic [IDX_W-1:0] rdidx_r;
  pnm_op_t          op_r;
  pnm_entry_t       key_r;

  logic                 out_valid_r, out_valid_nxt;
  pnm_status_t          status_r, status_nxt;
  logic [OUT_IDX_W-1:0] oidx_r, oidx_nxt;
  logic [DIST_W-1:0]    odist_r, odist_nxt;
  logic [CODE_W-1:0]    obg_r, obg_nxt, ofg_r, ofg_nxt;
  logic [GLYPH_W-1:0]   ogl_r, ogl_nxt;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign last_issue = (scan_r + CNT_W'(1)) == count_r;
  assign full       = count_r == CNT_W'(TABLE_ENTRIES);
  assign do_append  = fin_go && (op_r == OP_INSERT) && !best.dup && !full;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (count_r == '0) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rdv_r && !best.busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    ram_re      = 1'b0;
    fin_go      = 1'b0;
    case (state_r)
      S_IDLE:   in_ch.ready = 1'b1;
      S_SCAN:   ram_re      = 1'b1;
      S_DRAIN:  ;
      S_FINISH: fin_go      = !out_valid_r || out_ch.ready;
      default:  ;
    endcase
  end

  assign ram_raddr     = scan_r[IDX_W-1:0];
  assign ram_we        = do_append;
  assign ram_waddr     = count_r[IDX_W-1:0];
  assign scan.start    = in_fire;
  assign scan.rd_valid = rdv_r;
  assign scan.rd_index = rdidx_r;
  assign key           = key_r;

  // datapath
  always_comb begin
    scan_nxt      = scan_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    oidx_nxt      = oidx_r;
    odist_nxt     = odist_r;
    obg_nxt       = obg_r;
    ofg_nxt       = ofg_r;
    ogl_nxt       = ogl_r;
    if (in_fire) begin
      scan_nxt = '0;
    end else if (ram_re) begin
      scan_nxt = scan_r + CNT_W'(1);
    end
    if (do_append) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (fin_go) begin
      out_valid_nxt = 1'b1;
      oidx_nxt      = '0;
      odist_nxt     = '0;
      obg_nxt       = '0;
      ofg_nxt       = '0;
      ogl_nxt       = '0;
      if (op_r == OP_INSERT) begin
        if (best.dup) begin
          status_nxt = ST_DUPLICATE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_INSERTED;
          oidx_nxt   = to_out_idx(count_r[IDX_W-1:0]);
        end
      end else if (count_r == '0) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt = ST_MATCH;
        oidx_nxt   = to_out_idx(best.index);
        odist_nxt  = best.distance;
        obg_nxt    = best.background;
        ofg_nxt    = best.foreground;
        ogl_nxt    = best.glyph;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rdv_r       <= ram_re;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r   <= scan_nxt;
    rdidx_r  <= ram_raddr;
    status_r <= status_nxt;
    oidx_r   <= oidx_nxt;
    odist_r  <= odist_nxt;
    obg_r    <= obg_nxt;
    ofg_r    <= ofg_nxt;
    ogl_r    <= ogl_nxt;
    if (in_fire) begin
      op_r             <= pnm_op_t'(in_ch.opcode);
      key_r.red        <= in_ch.red;
      key_r.green      <= in_ch.green;
      key_r.blue       <= in_ch.blue;
      key_r.background <= in_ch.background;
      key_r.foreground <= in_ch.foreground;
      key_r.glyph      <= in_ch.glyph;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.entry_index      = oidx_r;
  assign out_ch.distance         = odist_r;
  assign out_ch.match_background = obg_r;
  assign out_ch.match_foreground = ofg_r;
  assign out_ch.match_glyph      = ogl_r;

endmodule

// ----- sv/palette_nearest_match.sv -----
// Top level of the palette table with duplicate-checked insert and nearest-color query.
//
//  channel | role   | transfer                  | payload
//  --------+--------+---------------------------+------------------------------------------
//  in_ch   | sink   | in_ch.valid & in_ch.ready | opcode, red, green, blue, background,
//          |        |                           | foreground, glyph
//  out_ch  | source | out_ch.valid & out_ch.ready | status, entry_index, distance,
//          |        |                           | match_background, match_foreground, match_glyph
//
// Scan: an item is compared against the stored entries by a scan through the table RAM,
//   one read per cycle, feeding one shared distance/compare unit; an empty table skips
//   the scan.
// Reset: synchronous, active low; empties the table (count to zero). Entry storage
//   is not cleared; only entries below the count are ever read.
// Stalls: in_ch.ready is high only while idle. A result held by out_ch does not block
//   the next input transfer; it stalls only the final step of the following item.
module palette_nearest_match (
  input  logic      clk,
  input  logic      rst_n,
  pnm_in_if.sink    in_ch,
  pnm_out_if.source out_ch
);
  import pnm_pkg::*;

  pnm_scan_t        scan;
  pnm_best_t        best;
  pnm_entry_t       key;
  pnm_entry_t       rd_data;
  logic             ram_re, ram_we;
  logic [IDX_W-1:0] ram_raddr, ram_waddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // sequencer: capture, scan pointer, append, result register
  pnm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .scan      (scan),
    .best      (best),
    .key       (key),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr)
  );

  // palette table; the write data is the captured item itself
  pnm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_data = pnm_entry_t'(ram_rdata);

  // one distance, equality check and running-minimum update per entry
  pnm_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .scan    (scan),
    .rd_data (rd_data),
    .key     (key),
    .best    (best)
  );

endmodule

// ----- sv/pnm_checker.sv -----
// Port-level checker for palette_nearest_match and its bind.
module pnm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pnm_pkg::STATUS_W-1:0]  status,
  input logic [pnm_pkg::OUT_IDX_W-1:0] entry_index,
  input logic [pnm_pkg::DIST_W-1:0]    distance,
  input logic [pnm_pkg::CODE_W-1:0]    match_background,
  input logic [pnm_pkg::CODE_W-1:0]    match_foreground,
  input logic [pnm_pkg::GLYPH_W-1:0]   match_glyph
);
  import pnm_pkg::*;

  // an accepted item makes the block busy, so ready is low in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready high right after an input transfer");

  // reset drops any pending result
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // only a match carries codes and distance
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_MATCH |->
      distance == '0 && match_background == '0 && match_foreground == '0 &&
      match_glyph == '0)
    else $error("nonzero match fields on a non-match result");

  // only insert and match report an index
  a_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_DUPLICATE || status == ST_FULL || status == ST_EMPTY) |->
      entry_index == '0)
    else $error("nonzero index on duplicate, full or empty result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_index) &&
      $stable(distance))
    else $error("stalled result changed");

endmodule

bind palette_nearest_match pnm_checker u_pnm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .status           (out_ch.status),
  .entry_index      (out_ch.entry_index),
  .distance         (out_ch.distance),
  .match_background (out_ch.match_background),
  .match_foreground (out_ch.match_foreground),
  .match_glyph      (out_ch.match_glyph)
);
